@@ design/gbts_pkg.sv @@
// ----------------------------------------------------------------------------
// gbts_pkg
// shared constants, field layout and codes of the gap buffer text store
// ----------------------------------------------------------------------------
package gbts_pkg;

  localparam int BUF_SIZE_DEF = 256;

  // field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int DIST_W = 10;
  localparam int IDX_W  = 8;
  localparam int STAT_W = 2;
  localparam int CUR_W  = 9;
  localparam int LEN_W  = 9;

  // stream data layout
  localparam int IN_DATA_W   = 32;
  localparam int IN_CHAR_LSB = 0;
  localparam int IN_DIST_LSB = 8;
  localparam int IN_IDX_LSB  = 18;

  localparam int OUT_DATA_W    = 40;
  localparam int OUT_STAT_LSB  = 0;
  localparam int OUT_DIST_LSB  = 2;
  localparam int OUT_CHAR_LSB  = 12;
  localparam int OUT_CUR_LSB   = 20;
  localparam int OUT_LEN_LSB   = 29;
  localparam int OUT_USED_W    = 38;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_MOVE   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

@@ design/gbts_ram.sv @@
// ----------------------------------------------------------------------------
// gbts_ram
// simple dual-port ram: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module gbts_ram #(
  parameter int WIDTH = gbts_pkg::CHAR_W,
  parameter int DEPTH = gbts_pkg::BUF_SIZE_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/gap_buffer_text_store_core.sv @@
// insert, delete and an out-of-range read go from idle straight to the emit state
// a read in range passes through the read wait state, as the ram read data is registered
// a cursor move passes through the move state, which copies n bytes, n the clamped distance:
// the copy engine moves one byte per cycle through the single ram read and write port
// one request at a time; the next is taken once the result sits in the output register
// synchronous active-low reset: empty text, cursor 0; ram contents are not cleared
// ----------------------------------------------------------------------------
// gap_buffer_text_store_core
// fixed-size gap buffer of bytes with insert, delete, cursor move and read
// ----------------------------------------------------------------------------
module gap_buffer_text_store_core #(
  parameter int BUF_SIZE = gbts_pkg::BUF_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // char_in[7:0], distance[17:8], read_index[25:18], zero pad
  input  logic [gbts_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd[1:0]
  input  logic [gbts_pkg::CMD_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[1:0], applied_distance[11:2], char_out[19:12], cursor[28:20],
  // text_length[37:29], zero pad
  output logic [gbts_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int AW = $clog2(BUF_SIZE);
  localparam int PW = $clog2(BUF_SIZE + 1);
  localparam int SW = ((PW + 1 > gbts_pkg::DIST_W) ? PW + 1 : gbts_pkg::DIST_W) + 1;
  localparam int XW = PW + gbts_pkg::IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDWAIT,
    S_MOVE,
    S_EMIT
  } state_t;

  state_t                          state_r;
  logic [PW-1:0]                   gs_r;
  logic [PW-1:0]                   gst_r;
  gbts_pkg::status_t               res_status_r;
  logic [gbts_pkg::DIST_W-1:0]     res_dist_r;
  logic [gbts_pkg::CHAR_W-1:0]     res_char_r;
  logic                            cp_fwd_r;
  logic [PW-1:0]                   cp_cnt_r;
  logic [AW-1:0]                   cp_rd_r;
  logic [AW-1:0]                   cp_wr_r;
  logic                            cp_pend_r;
  logic                            out_tvalid_r;
  logic [gbts_pkg::OUT_DATA_W-1:0] out_data_r;

  gbts_pkg::cmd_t                  cmd;
  logic [gbts_pkg::CHAR_W-1:0]     char_in;
  logic signed [gbts_pkg::DIST_W-1:0] dist_in;
  logic [gbts_pkg::IDX_W-1:0]      idx_in;
  logic                            in_acc;
  logic                            out_free;

  logic [PW-1:0]                   gap_len;
  logic [PW-1:0]                   text_len;
  logic                            full;
  logic [PW-1:0]                   gs_dec;
  logic [PW-1:0]                   gst_dec;

  logic signed [SW-1:0]            start_s;
  logic signed [SW-1:0]            stop_s;
  logic signed [SW-1:0]            dist_s;
  logic signed [SW-1:0]            buf_s;
  logic signed [SW-1:0]            sum_lo;
  logic signed [SW-1:0]            sum_hi;
  logic signed [SW-1:0]            clamp_s;
  logic signed [SW-1:0]            mag_s;

  logic [XW-1:0]                   idx_x;
  logic                            beyond;
  logic [XW-1:0]                   raddr_x;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [gbts_pkg::CHAR_W-1:0]     ram_wdata;
  logic [AW-1:0]                   ram_raddr;
  logic [gbts_pkg::CHAR_W-1:0]     ram_rdata;

  logic [gbts_pkg::OUT_DATA_W-1:0] out_pack;

  assign cmd     = gbts_pkg::cmd_t'(in_tuser);
  assign char_in = in_tdata[gbts_pkg::IN_CHAR_LSB +: gbts_pkg::CHAR_W];
  assign dist_in = signed'(in_tdata[gbts_pkg::IN_DIST_LSB +: gbts_pkg::DIST_W]);
  assign idx_in  = in_tdata[gbts_pkg::IN_IDX_LSB +: gbts_pkg::IDX_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign gap_len  = gst_r - gs_r;
  assign text_len = PW'(BUF_SIZE) - gap_len;
  // full when one free slot or fewer remains
  assign full     = ({1'b0, gs_r} + 1'b1) >= {1'b0, gst_r};
  assign gs_dec   = gs_r - 1'b1;
  assign gst_dec  = gst_r - 1'b1;

  // cursor move clamp
  always_comb begin
    start_s = signed'(SW'(gs_r));
    stop_s  = signed'(SW'(gst_r));
    dist_s  = SW'(dist_in);
    buf_s   = signed'(SW'(BUF_SIZE));
    sum_lo  = start_s + dist_s;
    sum_hi  = stop_s + dist_s;
    if (dist_s == '0) begin
      clamp_s = '0;
    end else if (sum_lo < 0) begin
      clamp_s = -start_s;
    end else if (sum_hi >= buf_s) begin
      clamp_s = buf_s - stop_s;
    end else begin
      clamp_s = dist_s;
    end
    mag_s = clamp_s[SW-1] ? -clamp_s : clamp_s;
  end

  // logical position to store slot
  always_comb begin
    idx_x   = XW'(idx_in);
    beyond  = idx_x >= XW'(text_len);
    raddr_x = (idx_x < XW'(gs_r)) ? idx_x : idx_x + XW'(gap_len);
  end

  // ram port steering: idle serves commands, move state serves the copy engine
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = gs_r[AW-1:0];
    ram_wdata = char_in;
    ram_raddr = raddr_x[AW-1:0];
    if (state_r == S_IDLE) begin
      ram_we = in_acc && (cmd == gbts_pkg::CMD_INSERT) && !full;
    end else begin
      ram_raddr = cp_rd_r;
      ram_waddr = cp_wr_r;
      ram_wdata = ram_rdata;
      ram_we    = (state_r == S_MOVE) && cp_pend_r;
    end
  end

  always_comb begin
    out_pack = '0;
    out_pack[gbts_pkg::OUT_STAT_LSB +: gbts_pkg::STAT_W] = res_status_r;
    out_pack[gbts_pkg::OUT_DIST_LSB +: gbts_pkg::DIST_W] = res_dist_r;
    out_pack[gbts_pkg::OUT_CHAR_LSB +: gbts_pkg::CHAR_W] = res_char_r;
    out_pack[gbts_pkg::OUT_CUR_LSB +: gbts_pkg::CUR_W]   = gbts_pkg::CUR_W'(gs_r);
    out_pack[gbts_pkg::OUT_LEN_LSB +: gbts_pkg::LEN_W]   = gbts_pkg::LEN_W'(text_len);
  end

  gbts_ram #(
    .WIDTH (gbts_pkg::CHAR_W),
    .DEPTH (BUF_SIZE)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      gs_r         <= '0;
      gst_r        <= PW'(BUF_SIZE);
      cp_pend_r    <= 1'b0;
      cp_cnt_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if ((state_r == S_EMIT) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (cmd)
              gbts_pkg::CMD_INSERT: begin
                res_dist_r <= '0;
                res_char_r <= '0;
                if (full) begin
                  res_status_r <= gbts_pkg::ST_FULL;
                end else begin
                  res_status_r <= gbts_pkg::ST_OK;
                  gs_r         <= gs_r + 1'b1;
                end
                state_r <= S_EMIT;
              end
              gbts_pkg::CMD_DELETE: begin
                res_status_r <= gbts_pkg::ST_OK;
                res_dist_r   <= '0;
                res_char_r   <= '0;
                if (gs_r != '0) begin
                  gs_r <= gs_dec;
                end
                state_r <= S_EMIT;
              end
              gbts_pkg::CMD_MOVE: begin
                res_status_r <= gbts_pkg::ST_OK;
                res_char_r   <= '0;
                res_dist_r   <= clamp_s[gbts_pkg::DIST_W-1:0];
                gs_r         <= gs_r + clamp_s[PW-1:0];
                gst_r        <= gst_r + clamp_s[PW-1:0];
                // forward copies ascending from gap end, backward descending into it
                cp_fwd_r     <= !clamp_s[SW-1];
                cp_cnt_r     <= mag_s[PW-1:0];
                cp_rd_r      <= clamp_s[SW-1] ? gs_dec[AW-1:0] : gst_r[AW-1:0];
                cp_wr_r      <= clamp_s[SW-1] ? gst_dec[AW-1:0] : gs_r[AW-1:0];
                cp_pend_r    <= 1'b0;
                state_r      <= S_MOVE;
              end
              gbts_pkg::CMD_READ: begin
                res_dist_r <= '0;
                res_char_r <= '0;
                if (beyond) begin
                  res_status_r <= gbts_pkg::ST_RANGE;
                  state_r      <= S_EMIT;
                end else begin
                  res_status_r <= gbts_pkg::ST_OK;
                  state_r      <= S_RDWAIT;
                end
              end
            endcase
          end
        end
        S_RDWAIT: begin
          res_char_r <= ram_rdata;
          state_r    <= S_EMIT;
        end
        S_MOVE: begin
          // read issued here lands in the write of the next cycle
          if (cp_cnt_r != '0) begin
            cp_cnt_r  <= cp_cnt_r - 1'b1;
            cp_rd_r   <= cp_fwd_r ? cp_rd_r + 1'b1 : cp_rd_r - 1'b1;
            cp_pend_r <= 1'b1;
          end else begin
            cp_pend_r <= 1'b0;
          end
          if (cp_pend_r) begin
            cp_wr_r <= cp_fwd_r ? cp_wr_r + 1'b1 : cp_wr_r - 1'b1;
          end
          if ((cp_cnt_r == '0) && !cp_pend_r) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_data_r <= out_pack;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ design/gbts_checker.sv @@
// ----------------------------------------------------------------------------
// gbts_checker
// port-level checks of the gap buffer text store, bound to the top level
// ----------------------------------------------------------------------------
module gbts_checker #(
  parameter int BUF_SIZE = gbts_pkg::BUF_SIZE_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gbts_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [gbts_pkg::STAT_W-1:0] o_status;
  logic [gbts_pkg::DIST_W-1:0] o_dist;
  logic [gbts_pkg::CHAR_W-1:0] o_char;
  logic [gbts_pkg::CUR_W-1:0]  o_cursor;
  logic [gbts_pkg::LEN_W-1:0]  o_len;

  assign o_status = out_tdata[gbts_pkg::OUT_STAT_LSB +: gbts_pkg::STAT_W];
  assign o_dist   = out_tdata[gbts_pkg::OUT_DIST_LSB +: gbts_pkg::DIST_W];
  assign o_char   = out_tdata[gbts_pkg::OUT_CHAR_LSB +: gbts_pkg::CHAR_W];
  assign o_cursor = out_tdata[gbts_pkg::OUT_CUR_LSB +: gbts_pkg::CUR_W];
  assign o_len    = out_tdata[gbts_pkg::OUT_LEN_LSB +: gbts_pkg::LEN_W];

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // one request in flight: never two in back-to-back cycles
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one busy");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (o_status == gbts_pkg::ST_FULL) |-> (o_dist == '0) && (o_char == '0))
    else $error("dropped insert reports move or byte");

  // text never fills the last slot and the cursor stays within the text
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (BUF_SIZE < 512) |-> (o_len <= BUF_SIZE - 1) && (o_cursor <= o_len))
    else $error("cursor or length out of bounds");

endmodule

bind gap_buffer_text_store_core gbts_checker #(.BUF_SIZE(BUF_SIZE)) u_gbts_checker (.*);

@@ sim/tb_gap_buffer_text_store_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gap_buffer_text_store_core
// drives insert, delete, cursor move and read requests into the gap buffer,
// mirrors the text and the gap in a scoreboard and checks every result field
// ----------------------------------------------------------------------------

typedef struct packed {
  gbts_pkg::status_t  status;
  logic signed [9:0]  applied;
  logic [7:0]         char_out;
  logic [8:0]         cursor;
  logic [8:0]         text_len;
} edit_result_t;

class gap_text_scoreboard;
  localparam int SLOTS = gbts_pkg::BUF_SIZE_DEF;

  logic [7:0]   slot_mem [SLOTS];
  int           gap_lo;
  int           gap_hi;
  edit_result_t pending [$];
  int           errors;

  function new();
    foreach (slot_mem[k]) slot_mem[k] = 8'h00;
    gap_lo = 0;
    gap_hi = SLOTS;
    errors = 0;
  endfunction

  function int text_len();
    return SLOTS - (gap_hi - gap_lo);
  endfunction

  // updates the mirrored text for one accepted request and queues its result
  function void note_request(gbts_pkg::cmd_t c, logic [7:0] ch, logic signed [9:0] d,
                             logic [7:0] idx);
    edit_result_t r;
    int           mv_dist;
    int           n;
    r = '0;
    r.status = gbts_pkg::ST_OK;
    mv_dist = 0;
    case (c)
      gbts_pkg::CMD_INSERT: begin
        if (gap_lo + 1 >= gap_hi) begin
          r.status = gbts_pkg::ST_FULL;
        end else begin
          slot_mem[gap_lo] = ch;
          gap_lo++;
        end
      end
      gbts_pkg::CMD_DELETE: begin
        if (gap_lo > 0) gap_lo--;
      end
      gbts_pkg::CMD_MOVE: begin
        mv_dist = int'(d);
        if (mv_dist != 0) begin
          if (gap_lo + mv_dist < 0) mv_dist = -gap_lo;
          else if (gap_hi + mv_dist >= SLOTS) mv_dist = SLOTS - gap_hi;
          if (mv_dist > 0) begin
            for (int k = 0; k < mv_dist; k++) slot_mem[gap_lo + k] = slot_mem[gap_hi + k];
          end else if (mv_dist < 0) begin
            n = -mv_dist;
            // copy from the top down, the ranges may overlap
            for (int k = n - 1; k >= 0; k--) slot_mem[gap_hi - n + k] = slot_mem[gap_lo - n + k];
          end
          gap_lo += mv_dist;
          gap_hi += mv_dist;
        end
      end
      default: begin
        if (int'(idx) >= text_len()) r.status = gbts_pkg::ST_RANGE;
        else if (int'(idx) < gap_lo) r.char_out = slot_mem[idx];
        else r.char_out = slot_mem[int'(idx) + gap_hi - gap_lo];
      end
    endcase
    r.applied  = mv_dist[9:0];
    r.cursor   = gap_lo[8:0];
    r.text_len = 9'(text_len());
    pending.push_back(r);
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task check_result(logic [gbts_pkg::OUT_DATA_W-1:0] data);
    edit_result_t want;
    logic [1:0]   got_status;
    logic [9:0]   got_applied;
    logic [7:0]   got_char;
    logic [8:0]   got_cursor;
    logic [8:0]   got_len;
    got_status  = data[gbts_pkg::OUT_STAT_LSB +: gbts_pkg::STAT_W];
    got_applied = data[gbts_pkg::OUT_DIST_LSB +: gbts_pkg::DIST_W];
    got_char    = data[gbts_pkg::OUT_CHAR_LSB +: gbts_pkg::CHAR_W];
    got_cursor  = data[gbts_pkg::OUT_CUR_LSB +: gbts_pkg::CUR_W];
    got_len     = data[gbts_pkg::OUT_LEN_LSB +: gbts_pkg::LEN_W];
    if (pending.size() == 0) begin
      report($sformatf("result 0x%h with no request outstanding", data));
      return;
    end
    want = pending.pop_front();
    if (got_status != want.status)
      report($sformatf("status got %0d expected %0d", got_status, want.status));
    if (got_applied != want.applied)
      report($sformatf("applied distance got %0d expected %0d",
                       $signed(got_applied), want.applied));
    if (got_char != want.char_out)
      report($sformatf("char out got 0x%h expected 0x%h", got_char, want.char_out));
    if (got_cursor != want.cursor)
      report($sformatf("cursor got %0d expected %0d", got_cursor, want.cursor));
    if (got_len != want.text_len)
      report($sformatf("text length got %0d expected %0d", got_len, want.text_len));
    if (data[gbts_pkg::OUT_DATA_W-1:gbts_pkg::OUT_USED_W] != '0)
      report($sformatf("pad bits set in 0x%h", data));
  endtask
endclass

module tb_gap_buffer_text_store_core;

  localparam int NUM_RANDOM   = 1300;
  localparam int PHASE_LEN    = 325;
  localparam int DRAIN_CYCLES = 300;
  localparam int LIMIT_CYCLES = 2_000_000;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [gbts_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [gbts_pkg::CMD_W-1:0]      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [gbts_pkg::OUT_DATA_W-1:0] out_tdata;

  gap_text_scoreboard sb;
  bit                 calm = 1'b0;
  int                 cycles = 0;

  gap_buffer_text_store_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_gap_buffer_text_store_core failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(gbts_pkg::cmd_t c, logic [7:0] ch, logic signed [9:0] d,
                              logic [7:0] idx);
    while (!calm && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {6'b0, idx, d, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(c, ch, d, idx);
    @(negedge clk);
  endtask

  function automatic logic signed [9:0] pick_distance();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 10'(int'($urandom_range(16)) - 8);
    if (p < 90) return 10'(int'($urandom_range(512)) - 256);
    case ($urandom_range(3))
      0: return -10'sd256;
      1: return 10'sd256;
      2: return 10'sd1;
      default: return -10'sd1;
    endcase
  endfunction

  function automatic logic [7:0] pick_index(int len);
    if (len > 0 && $urandom_range(99) < 75) return 8'($urandom_range(len - 1));
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int             phase;
    int             p;
    gbts_pkg::cmd_t c;
    sb = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = gbts_pkg::CMD_INSERT;
    out_tready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty text: out-of-range read, delete at start, zero and clamped moves, then four inserts and reads
    send_request(gbts_pkg::CMD_READ,   8'($urandom), pick_distance(), 8'd0);
    send_request(gbts_pkg::CMD_DELETE, 8'($urandom), pick_distance(), 8'($urandom));
    send_request(gbts_pkg::CMD_MOVE,   8'($urandom), 10'sd0,          8'($urandom));
    send_request(gbts_pkg::CMD_MOVE,   8'($urandom), -10'sd256,       8'($urandom));
    send_request(gbts_pkg::CMD_MOVE,   8'($urandom), 10'sd256,        8'($urandom));
    send_request(gbts_pkg::CMD_INSERT, 8'h00, pick_distance(), 8'($urandom));
    send_request(gbts_pkg::CMD_INSERT, 8'hff, pick_distance(), 8'($urandom));
    send_request(gbts_pkg::CMD_INSERT, 8'ha5, pick_distance(), 8'($urandom));
    send_request(gbts_pkg::CMD_INSERT, 8'h5a, pick_distance(), 8'($urandom));
    send_request(gbts_pkg::CMD_READ,   8'($urandom), pick_distance(), 8'd0);
    send_request(gbts_pkg::CMD_READ,   8'($urandom), pick_distance(), 8'd3);
    send_request(gbts_pkg::CMD_READ,   8'($urandom), pick_distance(), 8'd4);
    send_request(gbts_pkg::CMD_READ,   8'($urandom), pick_distance(), 8'd255);
    // gap to the front, then reads from behind the gap, more moves, a delete and an insert
    send_request(gbts_pkg::CMD_MOVE,   8'($urandom), -10'sd256, 8'($urandom));
    send_request(gbts_pkg::CMD_READ,   8'($urandom), pick_distance(), 8'd0);
    send_request(gbts_pkg::CMD_MOVE,   8'($urandom), 10'sd2,    8'($urandom));
    send_request(gbts_pkg::CMD_READ,   8'($urandom), pick_distance(), 8'd1);
    send_request(gbts_pkg::CMD_READ,   8'($urandom), pick_distance(), 8'd2);
    send_request(gbts_pkg::CMD_MOVE,   8'($urandom), 10'sd256,  8'($urandom));
    send_request(gbts_pkg::CMD_MOVE,   8'($urandom), -10'sd1,   8'($urandom));
    send_request(gbts_pkg::CMD_DELETE, 8'($urandom), pick_distance(), 8'($urandom));
    send_request(gbts_pkg::CMD_INSERT, 8'h3c, pick_distance(), 8'($urandom));
    send_request(gbts_pkg::CMD_READ,   8'($urandom), pick_distance(), 8'd2);

    // phases: fill past full, mixed editing, drain, mixed editing
    for (int i = 0; i < NUM_RANDOM; i++) begin
      phase = i / PHASE_LEN;
      calm  = (i >= 500 && i < 700);
      p     = $urandom_range(99);
      case (phase)
        0: c = (p < 85) ? gbts_pkg::CMD_INSERT : (p < 88) ? gbts_pkg::CMD_DELETE :
               (p < 94) ? gbts_pkg::CMD_MOVE : gbts_pkg::CMD_READ;
        2: c = (p < 10) ? gbts_pkg::CMD_INSERT : (p < 75) ? gbts_pkg::CMD_DELETE :
               (p < 87) ? gbts_pkg::CMD_MOVE : gbts_pkg::CMD_READ;
        default: c = (p < 35) ? gbts_pkg::CMD_INSERT : (p < 55) ? gbts_pkg::CMD_DELETE :
                     (p < 80) ? gbts_pkg::CMD_MOVE : gbts_pkg::CMD_READ;
      endcase
      send_request(c, 8'($urandom), pick_distance(), pick_index(sb.text_len()));
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_gap_buffer_text_store_core passed");
    end else begin
      $display("tb_gap_buffer_text_store_core failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/gbts_pkg.sv
design/gbts_ram.sv
design/gap_buffer_text_store_core.sv
design/gbts_checker.sv
sim/tb_gap_buffer_text_store_core.sv
